[sv/ksub_pkg.sv]
package ksub_pkg;

  localparam int COORD_W  = 28;
  localparam int LEN_W    = COORD_W - 1;
  localparam int THIRD_W  = COORD_W - 2;
  localparam int DIR_W    = 4;
  localparam int IDX_W    = 2;
  localparam int MAG_W    = 32;
  localparam int COEF_W   = MAG_W + 1;
  localparam int TRIG_FRAC = 30;
  localparam int PROD_W   = LEN_W + MAG_W;
  localparam int QUOT_W   = PROD_W - TRIG_FRAC;
  localparam int RECIP_SHIFT = 33;
  localparam int QPROD_W  = QUOT_W + MAG_W;
  localparam int LP1_W    = LEN_W + 1;
  localparam int TPROD_W  = LP1_W + MAG_W;
  localparam int SUM_W    = COORD_W + 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 88;

  localparam logic [DIR_W-1:0] DIR_COUNT = 4'd12;

  // ceil(2^33 / 3): exact floor division by three below 2^32
  localparam logic [MAG_W-1:0] RECIP3 = 32'hAAAA_AAAB;
  // half of three units of the trig scale, for round to nearest
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd3 << (TRIG_FRAC - 1));

  localparam logic signed [COEF_W-1:0] TRIG_ONE  = 33'sd1073741824;
  localparam logic signed [COEF_W-1:0] TRIG_ROOT = 33'sd929887697;
  localparam logic signed [COEF_W-1:0] TRIG_HALF = 33'sd536870912;

  localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] COORD_MIN = SUM_W'(-(64'sd1 <<< (COORD_W - 1)));

  typedef enum logic [IDX_W-1:0] {
    PIECE_START      = 2'd0,
    PIECE_TWO_THIRDS = 2'd1,
    PIECE_RISE       = 2'd2,
    PIECE_FALL       = 2'd3
  } piece_kind_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEN_W-1:0]   len;
    logic [DIR_W-1:0]   dir;
  } seg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEN_W-1:0]   len;
    logic [MAG_W-1:0]   mag_x;
    logic               neg_x;
    logic [MAG_W-1:0]   mag_y;
    logic               neg_y;
    logic [DIR_W-1:0]   dir;
    piece_kind_t        kind;
  } piece_t;

  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } stage_en_t;

  function automatic logic [DIR_W-1:0] mod12(input logic [DIR_W:0] v);
    logic [DIR_W:0] r;
    r = (v >= {1'b0, DIR_COUNT}) ? v - {1'b0, DIR_COUNT} : v;
    return r[DIR_W-1:0];
  endfunction

  // cosine in 30 degree steps, Q30
  function automatic logic signed [COEF_W-1:0] trig_cos(input logic [DIR_W-1:0] d);
    logic signed [COEF_W-1:0] c;
    unique case (d)
      4'd0:    c = TRIG_ONE;
      4'd1:    c = TRIG_ROOT;
      4'd2:    c = TRIG_HALF;
      4'd3:    c = '0;
      4'd4:    c = -TRIG_HALF;
      4'd5:    c = -TRIG_ROOT;
      4'd6:    c = -TRIG_ONE;
      4'd7:    c = -TRIG_ROOT;
      4'd8:    c = -TRIG_HALF;
      4'd9:    c = '0;
      4'd10:   c = TRIG_HALF;
      4'd11:   c = TRIG_ROOT;
      default: c = '0;
    endcase
    return c;
  endfunction

  // offset coefficient of a piece along one axis, in thirds of the length
  function automatic logic signed [COEF_W-1:0] koch_coef(input piece_kind_t k,
                                                         input logic [DIR_W-1:0] d,
                                                         input logic is_y);
    logic [DIR_W-1:0] a;
    logic [DIR_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    a = is_y ? mod12({1'b0, d} + 5'd9)  : d;
    b = is_y ? mod12({1'b0, d} + 5'd11) : mod12({1'b0, d} + 5'd2);
    unique case (k)
      PIECE_START:      c = '0;
      PIECE_TWO_THIRDS: c = trig_cos(a) <<< 1;
      PIECE_RISE:       c = trig_cos(a);
      PIECE_FALL:       c = trig_cos(a) + trig_cos(b);
      default:          c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [DIR_W-1:0] piece_dir(input piece_kind_t k,
                                                 input logic [DIR_W-1:0] d);
    logic [DIR_W-1:0] r;
    unique case (k)
      PIECE_RISE: r = mod12({1'b0, d} + 5'd2);
      PIECE_FALL: r = mod12({1'b0, d} + 5'd10);
      default:    r = d;
    endcase
    return r;
  endfunction

endpackage

[sv/ksub_issue.sv]
module ksub_issue import ksub_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  seg_t   in_seg,
  input  logic   s1_ready,
  output logic   s1_valid,
  output piece_t s1_piece
);

  logic        hold_valid_r, hold_valid_nxt;
  seg_t        hold_r, hold_nxt;
  piece_kind_t kind_r, kind_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  piece_t      s1_r, s1_nxt;

  logic rdy1, issue, last_issue, accept;
  logic signed [COEF_W-1:0] cx, cy;
  logic [COEF_W-1:0] ax, ay;

  assign rdy1       = !s1_valid_r || s1_ready;
  assign issue      = hold_valid_r && rdy1;
  assign last_issue = issue && (kind_r == PIECE_FALL);
  assign in_ready   = !hold_valid_r || last_issue;
  assign accept     = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    kind_nxt       = kind_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
      kind_nxt       = PIECE_START;
    end else if (issue) begin
      hold_valid_nxt = !last_issue;
      kind_nxt       = piece_kind_t'(kind_r + 2'd1);
    end
    s1_valid_nxt = rdy1 ? hold_valid_r : s1_valid_r;

    // direction codes above eleven wrap once
    hold_nxt     = in_seg;
    hold_nxt.dir = mod12({1'b0, in_seg.dir});

    cx = koch_coef(kind_r, hold_r.dir, 1'b0);
    cy = koch_coef(kind_r, hold_r.dir, 1'b1);
    ax = cx[COEF_W-1] ? COEF_W'(-cx) : COEF_W'(cx);
    ay = cy[COEF_W-1] ? COEF_W'(-cy) : COEF_W'(cy);

    s1_nxt.x     = hold_r.x;
    s1_nxt.y     = hold_r.y;
    s1_nxt.len   = hold_r.len;
    s1_nxt.mag_x = ax[MAG_W-1:0];
    s1_nxt.neg_x = cx[COEF_W-1];
    s1_nxt.mag_y = ay[MAG_W-1:0];
    s1_nxt.neg_y = cy[COEF_W-1];
    s1_nxt.dir   = piece_dir(kind_r, hold_r.dir);
    s1_nxt.kind  = kind_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      kind_r       <= PIECE_START;
      s1_valid_r   <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      kind_r       <= kind_nxt;
      s1_valid_r   <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
    end
    if (issue) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_piece = s1_r;

endmodule

[sv/ksub_offset.sv]
module ksub_offset import ksub_pkg::*; (
  input  logic               clk,
  input  stage_en_t          ctrl,
  input  logic [LEN_W-1:0]   len,
  input  logic [MAG_W-1:0]   mag,
  input  logic               neg,
  output logic [COORD_W-1:0] off_mag,
  output logic               off_neg
);

  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               neg2_r, neg3_r, neg4_r;
  logic [QUOT_W-1:0]  quot_r, quot_nxt;
  logic [PROD_W-1:0]  rounded;
  logic [QPROD_W-1:0] qprod_r, qprod_nxt;

  always_comb begin
    prod_nxt  = PROD_W'(len) * PROD_W'(mag);
    // round to nearest over three trig units: add half, drop the trig scale
    rounded   = prod_r + ROUND_HALF;
    quot_nxt  = rounded[PROD_W-1:TRIG_FRAC];
    qprod_nxt = QPROD_W'(quot_r) * QPROD_W'(RECIP3);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      prod_r <= prod_nxt;
      neg2_r <= neg;
    end
    if (ctrl.en3) begin
      quot_r <= quot_nxt;
      neg3_r <= neg2_r;
    end
    if (ctrl.en4) begin
      qprod_r <= qprod_nxt;
      neg4_r  <= neg3_r;
    end
  end

  assign off_mag = qprod_r[RECIP_SHIFT +: COORD_W];
  assign off_neg = neg4_r;

endmodule

[sv/koch_segment_subdivider.sv]
// Koch subdivision of one segment into four pieces of a third of its length,
// issued in order: at the start, at two thirds, at one third turned +60
// degrees, and at the peak turned -60 degrees, with start points rounded to
// nearest and saturated to the coordinate range. The issue stage emits one
// piece per cycle while the next stage can take it, and takes the next
// segment in the cycle that the current segment's fourth piece leaves. Each
// piece goes through a register pipeline (issue and coefficient lookup,
// length multiply, rounding, divide by three as a reciprocal multiply, add
// and saturate). The block keeps no state between segments and needs no
// start-up time after reset.
module koch_segment_subdivider import ksub_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, seg_length, direction
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // piece_x, piece_y, piece_length, piece_direction
  output logic [OUT_DATA_W-1:0] out_tdata,
  // piece_index
  output logic [IDX_W-1:0]      out_tuser,
  output logic                  out_tlast
);

  seg_t      in_seg;
  piece_t    s1_piece;
  logic      s1_valid;
  stage_en_t ctrl;

  logic v2_r, v3_r, v4_r, out_valid_r;
  logic v2_nxt, v3_nxt, v4_nxt, out_valid_nxt;
  logic rdy2, rdy3, rdy4, rdy5;

  logic [COORD_W-1:0] x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;
  logic [DIR_W-1:0]   d2_r, d3_r, d4_r;
  piece_kind_t        k2_r, k3_r, k4_r;
  logic [TPROD_W-1:0] tprod_r, tprod_nxt;
  logic [THIRD_W-1:0] third3_r, third4_r;

  logic [COORD_W-1:0] offx_mag, offy_mag;
  logic               offx_neg, offy_neg;

  logic [COORD_W-1:0] out_x_r, out_y_r, out_x_nxt, out_y_nxt;
  logic [THIRD_W-1:0] out_len_r;
  logic [DIR_W-1:0]   out_dir_r;
  piece_kind_t        out_kind_r;

  function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] base,
                                               input logic [COORD_W-1:0] mag,
                                               input logic neg);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] b;
    logic signed [SUM_W-1:0] o;
    b = SUM_W'(signed'(base));
    o = signed'(SUM_W'(mag));
    s = neg ? b - o : b + o;
    if (s > COORD_MAX) begin
      s = COORD_MAX;
    end else if (s < COORD_MIN) begin
      s = COORD_MIN;
    end
    return s[COORD_W-1:0];
  endfunction

  assign in_seg.x   = in_tdata[0 +: COORD_W];
  assign in_seg.y   = in_tdata[COORD_W +: COORD_W];
  assign in_seg.len = in_tdata[2*COORD_W +: LEN_W];
  assign in_seg.dir = in_tdata[2*COORD_W+LEN_W +: DIR_W];

  // per-stage ready, so bubbles close up behind a stalled result
  assign rdy5 = !out_valid_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;

  assign ctrl.en2 = rdy2 && s1_valid;
  assign ctrl.en3 = rdy3 && v2_r;
  assign ctrl.en4 = rdy4 && v3_r;

  ksub_issue u_issue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_seg   (in_seg),
    .s1_ready (rdy2),
    .s1_valid (s1_valid),
    .s1_piece (s1_piece)
  );

  ksub_offset u_off_x (
    .clk     (clk),
    .ctrl    (ctrl),
    .len     (s1_piece.len),
    .mag     (s1_piece.mag_x),
    .neg     (s1_piece.neg_x),
    .off_mag (offx_mag),
    .off_neg (offx_neg)
  );

  ksub_offset u_off_y (
    .clk     (clk),
    .ctrl    (ctrl),
    .len     (s1_piece.len),
    .mag     (s1_piece.mag_y),
    .neg     (s1_piece.neg_y),
    .off_mag (offy_mag),
    .off_neg (offy_neg)
  );

  always_comb begin
    v2_nxt        = rdy2 ? s1_valid : v2_r;
    v3_nxt        = rdy3 ? v2_r : v3_r;
    v4_nxt        = rdy4 ? v3_r : v4_r;
    out_valid_nxt = rdy5 ? v4_r : out_valid_r;
    // (len + 1) / 3 by reciprocal
    tprod_nxt = TPROD_W'(LP1_W'(s1_piece.len) + LP1_W'(1)) * TPROD_W'(RECIP3);
    out_x_nxt = place(x4_r, offx_mag, offx_neg);
    out_y_nxt = place(y4_r, offy_mag, offy_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      x2_r    <= s1_piece.x;
      y2_r    <= s1_piece.y;
      d2_r    <= s1_piece.dir;
      k2_r    <= s1_piece.kind;
      tprod_r <= tprod_nxt;
    end
    if (ctrl.en3) begin
      x3_r     <= x2_r;
      y3_r     <= y2_r;
      d3_r     <= d2_r;
      k3_r     <= k2_r;
      third3_r <= tprod_r[RECIP_SHIFT +: THIRD_W];
    end
    if (ctrl.en4) begin
      x4_r     <= x3_r;
      y4_r     <= y3_r;
      d4_r     <= d3_r;
      k4_r     <= k3_r;
      third4_r <= third3_r;
    end
    if (rdy5 && v4_r) begin
      out_x_r    <= out_x_nxt;
      out_y_r    <= out_y_nxt;
      out_len_r  <= third4_r;
      out_dir_r  <= d4_r;
      out_kind_r <= k4_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 2*COORD_W - THIRD_W - DIR_W)'(0),
                       out_dir_r, out_len_r, out_y_r, out_x_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = (out_kind_r == PIECE_FALL);

`ifndef ASSERT_OFF
  // a taken segment keeps the issue stage busy for its remaining pieces
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again straight after a transaction");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*COORD_W+THIRD_W +: DIR_W] < DIR_COUNT))
    else $error("piece direction out of range");

  // piece after the last one of a segment starts a new segment
  a_piece_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=>
      (!out_tvalid || (out_tuser == PIECE_START)))
    else $error("piece order broken after last piece");
`endif

endmodule
